### rtl/rxrb_pkg.sv
// Shared constants and codes for the receive ring buffer line reader.
`timescale 1ns / 1ps

package rxrb_pkg;

  // Default number of bytes held in the ring
  localparam int unsigned FIFO_DEPTH = 64;

  // Payload widths
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned ROOM_W  = 7;
  localparam int unsigned CCNT_W  = 6;
  localparam int unsigned FILL_W  = 7;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_RX_BYTE   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ_CHAR = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ_LINE = 2'd2;

  // Longest line delivered by one read-line item
  localparam logic [CCNT_W-1:0] MAX_LINE = 6'd63;

  // Delimiter after reset: newline
  localparam logic [BYTE_W-1:0] DELIM_RESET = 8'd10;

endpackage

### rtl/rxrb_req_if.sv
// Request channel: valid/ready handshake carrying one request item.
`timescale 1ns / 1ps

interface rxrb_req_if;
  logic                          valid;
  logic                          ready;
  logic [rxrb_pkg::REQ_W-1:0]    req_type;
  logic [rxrb_pkg::BYTE_W-1:0]   rx_byte;
  logic [rxrb_pkg::ROOM_W-1:0]   line_room;

  modport source (output valid, output req_type, output rx_byte, output line_room,
                  input ready);
  modport sink   (input valid, input req_type, input rx_byte, input line_room,
                  output ready);
endinterface

### rtl/rxrb_rsp_if.sv
// Response channel: valid/ready handshake carrying one result item.
`timescale 1ns / 1ps

interface rxrb_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [rxrb_pkg::BYTE_W-1:0]   out_byte;
  logic                          has_data;
  logic                          last;
  logic [rxrb_pkg::CCNT_W-1:0]   char_count;
  logic                          dropped;
  logic [rxrb_pkg::FILL_W-1:0]   fill_level;

  modport source (output valid, output out_byte, output has_data, output last,
                  output char_count, output dropped, output fill_level,
                  input ready);
  modport sink   (input valid, input out_byte, input has_data, input last,
                  input char_count, input dropped, input fill_level,
                  output ready);
endinterface

### rtl/rxrb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module rxrb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### rtl/rx_ring_buffer_line_reader_unit.sv
// Receive ring buffer with byte, character and line read requests.
`timescale 1ns / 1ps

// Receive FIFO for a serial port, one request item at a time. A receive item
// stores its byte (or reports it dropped when full) and answers. A read-char
// item reads the byte store, then answers. A read-line item first scans the
// stored bytes for the delimiter, a read and a compare per byte examined (up
// to the fill level; skipped when the FIFO is full), then pops the bytes it
// delivers, a read and a pop per byte. These steps come from the single
// synchronous byte store: each byte needs a read-issue step and a step to use
// the registered read data. Line reads that do not qualify produce no result
// and free the block at once or once the scan ends. The byte store needs no
// clearing after reset. A finished result waits in the output register while
// the next item is accepted; a new result is only produced once it is taken.
// The delimiter register may be written whenever no request is in progress.
module rx_ring_buffer_line_reader_unit #(
  parameter int unsigned FIFO_DEPTH = rxrb_pkg::FIFO_DEPTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [rxrb_pkg::BYTE_W-1:0] cfg_wdata_i,
  rxrb_req_if.sink                    req_i,
  rxrb_rsp_if.source                  rsp_o
);

  localparam int unsigned IdxW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(FIFO_DEPTH + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(FIFO_DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(FIFO_DEPTH);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_RX       = 3'd1;
  localparam logic [2:0] S_RD       = 3'd2;
  localparam logic [2:0] S_POP      = 3'd3;
  localparam logic [2:0] S_SCAN_RD  = 3'd4;
  localparam logic [2:0] S_SCAN_CMP = 3'd5;

  logic [2:0]                  state_q, state_d;
  logic [IdxW-1:0]             widx_q, widx_d;
  logic [IdxW-1:0]             ridx_q, ridx_d;
  logic [CntW-1:0]             count_q, count_d;
  logic [rxrb_pkg::BYTE_W-1:0] delim_q;
  logic                        line_q, line_d;
  logic [rxrb_pkg::BYTE_W-1:0] rx_byte_q, rx_byte_d;
  logic [rxrb_pkg::CCNT_W-1:0] limit_q, limit_d;
  logic [rxrb_pkg::CCNT_W-1:0] k_q, k_d;
  logic [IdxW-1:0]             scan_idx_q, scan_idx_d;
  logic [CntW-1:0]             scan_left_q, scan_left_d;

  logic                        out_valid_q, out_valid_d;
  logic [rxrb_pkg::BYTE_W-1:0] out_byte_q, out_byte_d;
  logic                        out_has_q, out_has_d;
  logic                        out_last_q, out_last_d;
  logic [rxrb_pkg::CCNT_W-1:0] out_ccnt_q, out_ccnt_d;
  logic                        out_drop_q, out_drop_d;
  logic [rxrb_pkg::FILL_W-1:0] out_fill_q, out_fill_d;

  logic                        slot_free;
  logic                        load_out;
  logic                        ram_we;
  logic                        ram_re;
  logic [IdxW-1:0]             ram_raddr;
  logic [rxrb_pkg::BYTE_W-1:0] ram_rdata;
  logic [rxrb_pkg::CCNT_W-1:0] k_next;
  logic [CntW-1:0]             count_dec;
  logic                        line_end;

  function automatic logic [IdxW-1:0] idx_inc(input logic [IdxW-1:0] idx);
    idx_inc = (idx == LastIdx) ? '0 : idx + 1'b1;
  endfunction

  rxrb_ram #(
    .WIDTH (rxrb_pkg::BYTE_W),
    .DEPTH (FIFO_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (widx_q),
    .wdata_i (rx_byte_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign slot_free   = !out_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == S_IDLE);
  assign k_next      = k_q + 1'b1;
  assign count_dec   = count_q - 1'b1;
  assign line_end    = (ram_rdata == delim_q) || (k_next >= limit_q) || (count_dec == '0);

  always_comb begin
    state_d     = state_q;
    widx_d      = widx_q;
    ridx_d      = ridx_q;
    count_d     = count_q;
    line_d      = line_q;
    rx_byte_d   = rx_byte_q;
    limit_d     = limit_q;
    k_d         = k_q;
    scan_idx_d  = scan_idx_q;
    scan_left_d = scan_left_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = ridx_q;
    load_out    = 1'b0;
    out_byte_d  = out_byte_q;
    out_has_d   = out_has_q;
    out_last_d  = out_last_q;
    out_ccnt_d  = out_ccnt_q;
    out_drop_d  = out_drop_q;
    out_fill_d  = out_fill_q;

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          rx_byte_d = req_i.rx_byte;
          k_d       = '0;
          case (req_i.req_type)
            rxrb_pkg::REQ_RX_BYTE: begin
              state_d = S_RX;
            end
            rxrb_pkg::REQ_READ_CHAR: begin
              line_d  = 1'b0;
              state_d = S_RD;
            end
            rxrb_pkg::REQ_READ_LINE: begin
              line_d  = 1'b1;
              limit_d = (req_i.line_room > 7'd64) ? rxrb_pkg::MAX_LINE
                                                  : 6'(req_i.line_room - 7'd1);
              if (req_i.line_room <= 7'd1 || count_q == '0) begin
                state_d = S_IDLE;
              end else if (count_q == FullCnt) begin
                // full ring qualifies without a delimiter
                state_d = S_RD;
              end else begin
                scan_idx_d  = ridx_q;
                scan_left_d = count_q;
                state_d     = S_SCAN_RD;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_RX: begin
        if (slot_free) begin
          load_out   = 1'b1;
          out_byte_d = '0;
          out_has_d  = 1'b0;
          out_last_d = 1'b1;
          out_ccnt_d = '0;
          if (count_q != FullCnt) begin
            ram_we     = 1'b1;
            widx_d     = idx_inc(widx_q);
            count_d    = count_q + 1'b1;
            out_drop_d = 1'b0;
          end else begin
            out_drop_d = 1'b1;
          end
          out_fill_d = rxrb_pkg::FILL_W'(count_d);
          state_d    = S_IDLE;
        end
      end

      S_RD: begin
        ram_re    = 1'b1;
        ram_raddr = ridx_q;
        state_d   = S_POP;
      end

      S_POP: begin
        if (slot_free) begin
          load_out   = 1'b1;
          out_drop_d = 1'b0;
          if (!line_q) begin
            out_last_d = 1'b1;
            out_ccnt_d = '0;
            if (count_q != '0) begin
              ridx_d     = idx_inc(ridx_q);
              count_d    = count_dec;
              out_byte_d = ram_rdata;
              out_has_d  = 1'b1;
            end else begin
              out_byte_d = '0;
              out_has_d  = 1'b0;
            end
            state_d = S_IDLE;
          end else begin
            ridx_d     = idx_inc(ridx_q);
            count_d    = count_dec;
            k_d        = k_next;
            out_byte_d = ram_rdata;
            out_has_d  = 1'b1;
            out_last_d = line_end;
            out_ccnt_d = k_next;
            state_d    = line_end ? S_IDLE : S_RD;
          end
          out_fill_d = rxrb_pkg::FILL_W'(count_d);
        end
      end

      S_SCAN_RD: begin
        ram_re    = 1'b1;
        ram_raddr = scan_idx_q;
        state_d   = S_SCAN_CMP;
      end

      S_SCAN_CMP: begin
        if (ram_rdata == delim_q) begin
          state_d = S_RD;
        end else if (scan_left_q == CntW'(1)) begin
          // no delimiter stored: nothing is answered
          state_d = S_IDLE;
        end else begin
          scan_idx_d  = idx_inc(scan_idx_q);
          scan_left_d = scan_left_q - 1'b1;
          state_d     = S_SCAN_RD;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      widx_q      <= '0;
      ridx_q      <= '0;
      count_q     <= '0;
      delim_q     <= rxrb_pkg::DELIM_RESET;
      line_q      <= 1'b0;
      limit_q     <= '0;
      k_q         <= '0;
      scan_idx_q  <= '0;
      scan_left_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      widx_q      <= widx_d;
      ridx_q      <= ridx_d;
      count_q     <= count_d;
      line_q      <= line_d;
      limit_q     <= limit_d;
      k_q         <= k_d;
      scan_idx_q  <= scan_idx_d;
      scan_left_q <= scan_left_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        delim_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rx_byte_q  <= rx_byte_d;
    out_byte_q <= out_byte_d;
    out_has_q  <= out_has_d;
    out_last_q <= out_last_d;
    out_ccnt_q <= out_ccnt_d;
    out_drop_q <= out_drop_d;
    out_fill_q <= out_fill_d;
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.out_byte   = out_byte_q;
  assign rsp_o.has_data   = out_has_q;
  assign rsp_o.last       = out_last_q;
  assign rsp_o.char_count = out_ccnt_q;
  assign rsp_o.dropped    = out_drop_q;
  assign rsp_o.fill_level = out_fill_q;

  // distance from read to write pointer, for the occupancy check
  logic [CntW:0] occ_dist;
  assign occ_dist = (widx_q >= ridx_q) ? (CntW+1)'(widx_q - ridx_q)
                  : (CntW+1)'(FIFO_DEPTH) + (CntW+1)'(widx_q) - (CntW+1)'(ridx_q);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("ring occupancy above depth");

  a_ptr_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_dist == ((count_q == FullCnt) ? '0 : (CntW+1)'(count_q)))
    else $error("pointers disagree with occupancy");

  a_no_write_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_RX) && (count_q != FullCnt))
    else $error("store written while full or outside receive");

  a_line_within_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP) && line_q |-> (k_q < limit_q) && (count_q != '0))
    else $error("line pop beyond limit or from empty ring");

  a_result_not_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> slot_free)
    else $error("result overwrote one not yet taken");

endmodule

### tb/testbench.sv
// Self-checking testbench for the receive ring buffer line reader.
`timescale 1ns / 1ps

module testbench;

  // Request code the block ignores
  localparam logic [rxrb_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
  // A line read that gives nothing still scans up to the whole ring
  localparam int unsigned SCAN_SETTLE = 2 * rxrb_pkg::FIFO_DEPTH + 64;

  typedef struct packed {
    logic [rxrb_pkg::REQ_W-1:0]  req_type;
    logic [rxrb_pkg::BYTE_W-1:0] rx_byte;
    logic [rxrb_pkg::ROOM_W-1:0] line_room;
  } rx_req_t;

  typedef struct packed {
    logic [rxrb_pkg::BYTE_W-1:0] out_byte;
    logic                        has_data;
    logic                        last;
    logic [rxrb_pkg::CCNT_W-1:0] char_count;
    logic                        dropped;
    logic [rxrb_pkg::FILL_W-1:0] fill_level;
  } rx_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [rxrb_pkg::BYTE_W-1:0] cfg_wdata_i;

  rxrb_req_if req_if ();
  rxrb_rsp_if rsp_if ();

  rx_ring_buffer_line_reader_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Ring mirror
  logic [rxrb_pkg::BYTE_W-1:0] ring_mem [rxrb_pkg::FIFO_DEPTH];
  int unsigned                 ring_rd;
  int unsigned                 ring_wr;
  int unsigned                 ring_fill;
  logic [rxrb_pkg::BYTE_W-1:0] ring_delim;

  rx_rsp_t awaited_rsp_q [$];
  int unsigned err_count;
  bit no_gaps;

  function automatic logic [rxrb_pkg::BYTE_W-1:0] ring_pop();
    logic [rxrb_pkg::BYTE_W-1:0] b;
    b = ring_mem[ring_rd];
    ring_rd = (ring_rd + 1) % rxrb_pkg::FIFO_DEPTH;
    ring_fill--;
    return b;
  endfunction

  function automatic bit ring_holds_delim();
    int unsigned idx;
    int unsigned n;
    idx = ring_rd;
    for (n = 0; n < ring_fill; n++) begin
      if (ring_mem[idx] == ring_delim) return 1'b1;
      idx = (idx + 1) % rxrb_pkg::FIFO_DEPTH;
    end
    return 1'b0;
  endfunction

  // Results that one accepted request must cause, in order
  function automatic void compute_ring_results(input rx_req_t r);
    rx_rsp_t res;
    int unsigned lim;
    int unsigned k;
    bit stop;
    logic [rxrb_pkg::BYTE_W-1:0] b;
    res = '0;
    case (r.req_type)
      rxrb_pkg::REQ_RX_BYTE: begin
        if (ring_fill < rxrb_pkg::FIFO_DEPTH) begin
          ring_mem[ring_wr] = r.rx_byte;
          ring_wr = (ring_wr + 1) % rxrb_pkg::FIFO_DEPTH;
          ring_fill++;
        end else begin
          res.dropped = 1'b1;
        end
        res.last = 1'b1;
        res.fill_level = rxrb_pkg::FILL_W'(ring_fill);
        awaited_rsp_q.push_back(res);
      end
      rxrb_pkg::REQ_READ_CHAR: begin
        if (ring_fill > 0) begin
          res.out_byte = ring_pop();
          res.has_data = 1'b1;
        end
        res.last = 1'b1;
        res.fill_level = rxrb_pkg::FILL_W'(ring_fill);
        awaited_rsp_q.push_back(res);
      end
      rxrb_pkg::REQ_READ_LINE: begin
        if (ring_fill == 0) return;
        if (ring_fill != rxrb_pkg::FIFO_DEPTH && !ring_holds_delim()) return;
        if (r.line_room <= 1) return;
        lim = r.line_room - 1;
        if (lim > rxrb_pkg::MAX_LINE) lim = rxrb_pkg::MAX_LINE;
        k = 0;
        stop = 1'b0;
        while (k < lim && ring_fill > 0 && !stop) begin
          b = ring_pop();
          k++;
          stop = (b == ring_delim);
          res = '0;
          res.out_byte = b;
          res.has_data = 1'b1;
          res.last = stop || k >= lim || ring_fill == 0;
          res.char_count = rxrb_pkg::CCNT_W'(k);
          res.fill_level = rxrb_pkg::FILL_W'(ring_fill);
          awaited_rsp_q.push_back(res);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void note_mismatch(input string what, input rx_rsp_t want,
                                        input rx_rsp_t got);
    err_count++;
    if (err_count <= 10)
      $display({"%0t: %s exp byte=%02h has=%b last=%b cnt=%0d drop=%b fill=%0d",
                " | got byte=%02h has=%b last=%b cnt=%0d drop=%b fill=%0d"},
               $realtime, what, want.out_byte, want.has_data, want.last, want.char_count,
               want.dropped, want.fill_level, got.out_byte, got.has_data, got.last,
               got.char_count, got.dropped, got.fill_level);
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    rx_rsp_t got;
    rx_rsp_t want;
    if (rst_ni === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      got = {rsp_if.out_byte, rsp_if.has_data, rsp_if.last, rsp_if.char_count,
             rsp_if.dropped, rsp_if.fill_level};
      if (awaited_rsp_q.size() == 0) begin
        note_mismatch("unexpected result", '0, got);
      end else begin
        want = awaited_rsp_q.pop_front();
        if (got !== want) note_mismatch("result differs", want, got);
      end
    end
  end

  // Result side: random stall before each item
  initial begin
    int unsigned stall;
    rsp_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 7);
      if (stall != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (rsp_if.valid !== 1'b1);
      @(negedge clk_i);
    end
  end

  // Starts and ends at a falling edge
  task automatic send_req(input logic [rxrb_pkg::REQ_W-1:0] kind,
                          input logic [rxrb_pkg::BYTE_W-1:0] b,
                          input logic [rxrb_pkg::ROOM_W-1:0] room);
    int unsigned gap;
    rx_req_t r;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    r.req_type = kind;
    r.rx_byte = b;
    r.line_room = room;
    req_if.valid <= 1'b1;
    req_if.req_type <= kind;
    req_if.rx_byte <= b;
    req_if.line_room <= room;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    compute_ring_results(r);
    @(negedge clk_i);
  endtask

  task automatic wait_ring_idle();
    req_if.valid <= 1'b0;
    while (awaited_rsp_q.size() != 0) @(negedge clk_i);
    repeat (SCAN_SETTLE) @(negedge clk_i);
  endtask

  task automatic write_delimiter(input logic [rxrb_pkg::BYTE_W-1:0] value);
    wait_ring_idle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    ring_delim = value;
  endtask

  function automatic logic [rxrb_pkg::BYTE_W-1:0] rand_byte();
    return rxrb_pkg::BYTE_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [rxrb_pkg::ROOM_W-1:0] rand_room();
    return rxrb_pkg::ROOM_W'($urandom_range(0, 127));
  endfunction

  function automatic logic [rxrb_pkg::BYTE_W-1:0] plain_byte();
    logic [rxrb_pkg::BYTE_W-1:0] b;
    do b = rand_byte(); while (b == ring_delim);
    return b;
  endfunction

  // Empty ring, ignored code, default delimiter
  task automatic test_empty_ring();
    send_req(rxrb_pkg::REQ_READ_CHAR, 8'hff, 7'd0);
    send_req(rxrb_pkg::REQ_READ_LINE, 8'h00, 7'd127);
    send_req(REQ_UNUSED, 8'h41, 7'd64);
    send_req(rxrb_pkg::REQ_READ_CHAR, 8'h00, 7'd0);
  endtask

  task automatic test_short_lines();
    send_req(rxrb_pkg::REQ_RX_BYTE, 8'h68, 7'd0);
    send_req(rxrb_pkg::REQ_RX_BYTE, 8'h69, 7'd0);
    send_req(rxrb_pkg::REQ_RX_BYTE, rxrb_pkg::DELIM_RESET, 7'd0);
    send_req(rxrb_pkg::REQ_READ_LINE, 8'h00, 7'd64);
    send_req(rxrb_pkg::REQ_RX_BYTE, 8'h00, 7'd0);
    send_req(rxrb_pkg::REQ_RX_BYTE, 8'hff, 7'd0);
    send_req(rxrb_pkg::REQ_RX_BYTE, rxrb_pkg::DELIM_RESET, 7'd0);
    // rooms of zero and one pop nothing
    send_req(rxrb_pkg::REQ_READ_LINE, 8'h00, 7'd0);
    send_req(rxrb_pkg::REQ_READ_LINE, 8'h00, 7'd1);
    send_req(rxrb_pkg::REQ_READ_LINE, 8'h00, 7'd2);
    send_req(rxrb_pkg::REQ_READ_LINE, 8'h00, 7'd127);
    // no delimiter held: line read gives nothing
    send_req(rxrb_pkg::REQ_RX_BYTE, 8'h55, 7'd0);
    send_req(rxrb_pkg::REQ_RX_BYTE, 8'haa, 7'd0);
    send_req(rxrb_pkg::REQ_READ_LINE, 8'h00, 7'd64);
    send_req(rxrb_pkg::REQ_READ_CHAR, 8'h00, 7'd0);
    send_req(rxrb_pkg::REQ_READ_CHAR, 8'h00, 7'd0);
    send_req(rxrb_pkg::REQ_READ_CHAR, 8'h00, 7'd0);
  endtask

  // Full ring: drops, and line reads capped at the line limit
  task automatic test_full_ring();
    int i;
    no_gaps = 1'b1;
    for (i = 0; i < rxrb_pkg::FIFO_DEPTH + 2; i++)
      send_req(rxrb_pkg::REQ_RX_BYTE, plain_byte(), 7'd0);
    no_gaps = 1'b0;
    send_req(rxrb_pkg::REQ_READ_LINE, 8'h00, 7'd127);
    send_req(rxrb_pkg::REQ_READ_LINE, 8'h00, 7'd64);
    send_req(rxrb_pkg::REQ_READ_CHAR, 8'h00, 7'd0);
    send_req(rxrb_pkg::REQ_READ_CHAR, 8'h00, 7'd0);
    for (i = 0; i < rxrb_pkg::FIFO_DEPTH - 1; i++)
      send_req(rxrb_pkg::REQ_RX_BYTE, plain_byte(), 7'd0);
    send_req(rxrb_pkg::REQ_RX_BYTE, ring_delim, 7'd0);
    send_req(rxrb_pkg::REQ_RX_BYTE, ring_delim, 7'd0);
    send_req(rxrb_pkg::REQ_READ_LINE, 8'h00, 7'd127);
    send_req(rxrb_pkg::REQ_READ_LINE, 8'h00, 7'd2);
    send_req(rxrb_pkg::REQ_READ_CHAR, 8'h00, 7'd0);
  endtask

  // Mostly whole lines with random content, some noise
  task automatic run_line_traffic(input int unsigned budget);
    int unsigned sent;
    int unsigned len;
    int unsigned room;
    int unsigned i;
    sent = 0;
    while (sent < budget) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) < 7) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 50) : $urandom_range(0, 12);
        for (i = 0; i < len; i++) send_req(rxrb_pkg::REQ_RX_BYTE, rand_byte(), 7'd0);
        if ($urandom_range(0, 3) != 0) begin
          send_req(rxrb_pkg::REQ_RX_BYTE, ring_delim, 7'd0);
          sent++;
        end
        if ($urandom_range(0, 5) == 0) room = $urandom_range(0, 127);
        else room = len + $urandom_range(0, 40);
        if (room > 127) room = 127;
        send_req(rxrb_pkg::REQ_READ_LINE, rand_byte(), rxrb_pkg::ROOM_W'(room));
        sent += len + 1;
        if ($urandom_range(0, 2) == 0) begin
          len = $urandom_range(1, 3);
          for (i = 0; i < len; i++) send_req(rxrb_pkg::REQ_READ_CHAR, rand_byte(), 7'd0);
          sent += len;
        end
      end else begin
        case ($urandom_range(0, 3))
          0: send_req(REQ_UNUSED, rand_byte(), rand_room());
          1: begin
            send_req(rxrb_pkg::REQ_READ_CHAR, rand_byte(), rand_room());
            sent++;
          end
          2: begin
            send_req(rxrb_pkg::REQ_READ_LINE, rand_byte(), rand_room());
            sent++;
          end
          default: begin
            send_req(rxrb_pkg::REQ_RX_BYTE, rand_byte(), rand_room());
            sent++;
          end
        endcase
      end
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_delimiter_settings();
    write_delimiter(8'h00);
    run_line_traffic(30);
    write_delimiter(8'hff);
    run_line_traffic(30);
    write_delimiter(rxrb_pkg::BYTE_W'($urandom_range(1, 254)));
    run_line_traffic(30);
    write_delimiter(rxrb_pkg::DELIM_RESET);
    run_line_traffic(30);
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    req_if.valid = 1'b0;
    req_if.req_type = rxrb_pkg::REQ_RX_BYTE;
    req_if.rx_byte = '0;
    req_if.line_room = '0;
    ring_rd = 0;
    ring_wr = 0;
    ring_fill = 0;
    ring_delim = rxrb_pkg::DELIM_RESET;
    err_count = 0;
    no_gaps = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_empty_ring();
    test_short_lines();
    test_full_ring();
    test_delimiter_settings();

    wait_ring_idle();
    if (err_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

### rx_ring_buffer_line_reader_unit.f
rtl/rxrb_pkg.sv
rtl/rxrb_req_if.sv
rtl/rxrb_rsp_if.sv
rtl/rxrb_ram.sv
rtl/rx_ring_buffer_line_reader_unit.sv
tb/testbench.sv
